[rtl/lsser_pkg.sv]
// Package for the list store engine: command and status codes, fixed field
// widths and the result record passed from the sequencer to the output stage.
// No dependencies.
package lsser_pkg;

    // Fixed widths of the stream fields
    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;

    // Largest reported length and largest number of entries one dump emits
    localparam int LEN_MAX  = 127;
    localparam int DUMP_MAX = 64;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SORT    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DUMP    = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // One result item
    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic        [INDEX_W-1:0] position;
        logic                      valid;
        logic        [LEN_W-1:0]   length;
        logic        [1:0]         status;
        logic                      last;
    } result_t;

endpackage

[rtl/lsser_mem.sv]
// Entry store of the list engine: one write port and one read port with a
// registered, enabled read. Depends on nothing.
module lsser_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [WIDTH-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [WIDTH-1:0] rd_data
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next enabled read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/lsser_seq.sv]
// Command sequencer of the list engine: runs each command as a series of
// memory steps around one signed compare. Depends on lsser_pkg.
module lsser_seq #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int AW         = $clog2(CAPACITY),
    localparam int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [lsser_pkg::FUNC_W-1:0]           in_func,
    input  logic signed [lsser_pkg::DATA_W-1:0]    in_data,
    input  logic [lsser_pkg::INDEX_W-1:0]          in_index,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output lsser_pkg::result_t                     res,
    output logic                                   mem_wr_en,
    output logic [AW-1:0]                          mem_wr_addr,
    output logic signed [VALUE_WIDTH-1:0]          mem_wr_data,
    output logic                                   mem_rd_en,
    output logic [AW-1:0]                          mem_rd_addr,
    input  logic signed [VALUE_WIDTH-1:0]          mem_rd_data
);

    localparam int LW     = (CW > lsser_pkg::LEN_W) ? CW : lsser_pkg::LEN_W;
    localparam int IW     = (CW > lsser_pkg::INDEX_W) ? CW : lsser_pkg::INDEX_W;
    localparam int DUMP_N = (CAPACITY < lsser_pkg::DUMP_MAX) ? CAPACITY : lsser_pkg::DUMP_MAX;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERS_RD,
        ST_ERS_MOV,
        ST_SORT_RDI,
        ST_SORT_LDI,
        ST_SORT_CMP,
        ST_SORT_WRI,
        ST_REV_RDA,
        ST_REV_RDB,
        ST_REV_WRA,
        ST_REV_WRB,
        ST_DMP_RD,
        ST_DMP_EMIT,
        ST_RESP
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 a_reg, a_next;
    logic [CW-1:0]                 b_reg, b_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic signed [VALUE_WIDTH-1:0] cur_reg, cur_next;
    logic [1:0]                    status_reg, status_next;

    logic [CW-1:0] a_inc, a_inc2, b_inc, b_dec, idx_c, idx_inc;
    logic [LW-1:0] count_ext;
    logic [lsser_pkg::LEN_W-1:0] length;
    logic          greater;
    logic          dmp_last;

    // Index arithmetic and the signed compare used by the sort
    assign a_inc     = a_reg + CW'(1);
    assign a_inc2    = a_reg + CW'(2);
    assign b_inc     = b_reg + CW'(1);
    assign b_dec     = b_reg - CW'(1);
    assign idx_c     = CW'(in_index);
    assign idx_inc   = idx_c + CW'(1);
    assign greater   = cur_reg > mem_rd_data;
    assign dmp_last  = (a_inc == count_reg) || (a_reg == CW'(DUMP_N - 1));
    assign count_ext = LW'(count_reg);
    assign length    = (count_ext > LW'(lsser_pkg::LEN_MAX)) ?
                       lsser_pkg::LEN_W'(lsser_pkg::LEN_MAX) : count_ext[lsser_pkg::LEN_W-1:0];

    // Next-state logic and memory port control
    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        status_next  = status_reg;
        in_ready     = (state_reg == ST_IDLE);
        mem_wr_en    = 1'b0;
        mem_wr_addr  = a_reg[AW-1:0];
        mem_wr_data  = cur_reg;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = a_reg[AW-1:0];
        res_valid    = 1'b0;
        res.value    = '0;
        res.position = '0;
        res.valid    = 1'b0;
        res.length   = length;
        res.status   = status_reg;
        res.last     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = lsser_pkg::STATUS_OK;
                    state_next  = ST_RESP;
                    case (in_func)
                        lsser_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        lsser_pkg::FUNC_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = lsser_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = count_reg[AW-1:0];
                                mem_wr_data = VALUE_WIDTH'(in_data);
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        lsser_pkg::FUNC_ERASE:
                        begin
                            if (IW'(in_index) >= IW'(count_reg))
                            begin
                                status_next = lsser_pkg::STATUS_RANGE;
                            end
                            else if (idx_inc < count_reg)
                            begin
                                a_next     = idx_c;
                                state_next = ST_ERS_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        lsser_pkg::FUNC_SORT:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                a_next     = '0;
                                state_next = ST_SORT_RDI;
                            end
                        end
                        lsser_pkg::FUNC_REVERSE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                a_next     = '0;
                                b_next     = count_reg - CW'(1);
                                state_next = ST_REV_RDA;
                            end
                        end
                        lsser_pkg::FUNC_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                a_next     = '0;
                                state_next = ST_DMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // Erase: shift the tail down one entry per cycle
            ST_ERS_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = a_inc[AW-1:0];
                state_next  = ST_ERS_MOV;
            end
            ST_ERS_MOV:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                if (a_inc2 < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = a_inc2[AW-1:0];
                    a_next      = a_inc;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end

            // Sort: the smallest value seen for entry i is held in cur_reg while j walks the rest
            ST_SORT_RDI:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_SORT_LDI;
            end
            ST_SORT_LDI:
            begin
                cur_next    = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = a_inc[AW-1:0];
                b_next      = a_inc;
                state_next  = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                if (greater)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = b_reg[AW-1:0];
                    mem_wr_data = cur_reg;
                    cur_next    = mem_rd_data;
                end
                if (b_inc < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = b_inc[AW-1:0];
                    b_next      = b_inc;
                end
                else
                begin
                    state_next = ST_SORT_WRI;
                end
            end
            ST_SORT_WRI:
            begin
                mem_wr_en = 1'b1;
                if (a_inc2 < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = a_inc[AW-1:0];
                    a_next      = a_inc;
                    state_next  = ST_SORT_LDI;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            // Reverse: swap the outer pair, then move both ends inward
            ST_REV_RDA:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_REV_RDB;
            end
            ST_REV_RDB:
            begin
                cur_next    = mem_rd_data;
                mem_rd_en   = 1'b1;
                mem_rd_addr = b_reg[AW-1:0];
                state_next  = ST_REV_WRA;
            end
            ST_REV_WRA:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                state_next  = ST_REV_WRB;
            end
            ST_REV_WRB:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = b_reg[AW-1:0];
                if (a_inc < b_dec)
                begin
                    a_next     = a_inc;
                    b_next     = b_dec;
                    state_next = ST_REV_RDA;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            // Dump: one entry per transfer, the next read issued on acceptance
            ST_DMP_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_DMP_EMIT;
            end
            ST_DMP_EMIT:
            begin
                res_valid    = 1'b1;
                res.value    = lsser_pkg::DATA_W'(mem_rd_data);
                res.position = lsser_pkg::INDEX_W'(a_reg);
                res.valid    = 1'b1;
                res.last     = dmp_last;
                if (res_ready)
                begin
                    if (dmp_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = a_inc[AW-1:0];
                        a_next      = a_inc;
                    end
                end
            end

            // Single closing result of every command but a non-empty dump
            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            status_reg <= lsser_pkg::STATUS_OK;
            a_reg      <= '0;
            b_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // The entry count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Writes made while a command runs stay inside the list
    a_wr_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && state_reg != ST_IDLE) |-> (CW'(mem_wr_addr) < count_reg))
        else $error("memory write outside the list during a command");

    // Only dump entries may be followed by more results
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.last) |-> (res.valid && state_reg == ST_DMP_EMIT))
        else $error("non-final result outside a dump");

    // An accepted command leaves the sequencer not ready right after its transfer
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after a command transfer");

endmodule

[rtl/list_store_sort_erase_reverse_top.sv]
// Top level of the list engine: stream ports, sequencer, entry store and the
// output register. Depends on lsser_pkg, lsser_seq and lsser_mem.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: data_value, position_index; tuser: func
//  m_axis    out        tdata: element_value, element_position, list_length;
//                       tuser: element_valid, status_code; tlast: last
//
// Clear, append, unused codes and refused commands go straight to the closing result.
// Erase of the last entry goes straight to the result; otherwise each later entry moves down in turn.
// Reverse: each swapped pair is read from both ends, then written back to both ends.
// Sort: one compare per cycle, bounded by the single read port of the entry store.
// Dump: the entries follow back to back while m_axis_tready is high.
// Reset clears the count and control; stalls on m_axis hold the sequencer.
module list_store_sort_erase_reverse_top #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_value[31:0], position_index[37:32]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // element_value[31:0], element_position[37:32],
                                        // list_length[44:38]
    output logic [2:0]  m_axis_tuser,   // element_valid[0], status_code[2:1]
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);

    logic                          res_valid;
    logic                          res_ready;
    lsser_pkg::result_t            res;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic signed [VALUE_WIDTH-1:0] mem_wr_data;
    logic                          mem_rd_en;
    logic [AW-1:0]                 mem_rd_addr;
    logic signed [VALUE_WIDTH-1:0] mem_rd_data;

    logic               out_valid_reg;
    lsser_pkg::result_t out_data_reg;

    // Command sequencer
    lsser_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (s_axis_tuser),
        .in_data     (s_axis_tdata[31:0]),
        .in_index    (s_axis_tdata[37:32]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Entry store
    lsser_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: takes a new result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg.length, out_data_reg.position,
                            out_data_reg.value};
    assign m_axis_tuser  = {out_data_reg.status, out_data_reg.valid};
    assign m_axis_tlast  = out_data_reg.last;

endmodule
